// ===== rtl/bspa_pkg.sv =====
// Package: shared types and constants for the Biot-Savart point accumulator.
package bspa_pkg;

   localparam int POS_FRAC_BITS = 20;
   localparam int NUM_SHIFT = 2 * POS_FRAC_BITS - 24;
   localparam logic [31:0] INV4PI_Q32 = 32'd341782638;
   localparam int SAT_W = 48;
   localparam int ROOT_BITS = 34;
   localparam int NUM_W = 128;
   localparam int DEN_W = 104;
   localparam logic signed [SAT_W-1:0] SAT_POS = {1'b0, {(SAT_W-1){1'b1}}};
   localparam logic signed [SAT_W-1:0] SAT_NEG = {1'b1, {(SAT_W-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_ROOT,
      ST_R2,
      ST_R3,
      ST_CROSS,
      ST_NUM,
      ST_DIV,
      ST_ACC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

// ===== rtl/biot_savart_point_accumulator_unit.sv =====
// Top level: Biot-Savart point accumulator with bit-serial multiply, root and divide.
//  channel | direction | handshake      | payload
//  req_    | in        | valid / stall  | target, source, strength, last_source
//  rsp_    | out       | valid / stall  | vel_x, vel_y, vel_z
//  csr_    | in        | valid / ready  | softening
// The run time of an item is set by the shared bit-serial multiplier (one bit a cycle,
// up to the top set bit of its second operand), the 34-step square root and three
// 128-step divides that stop early on saturation.
// Reset clears the sums and loads softening with 1049.
// A held result stalls the next item only at its own output; req_stall is high while busy.
module biot_savart_point_accumulator_unit
   import bspa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [31:0]      req_target_x,
   input  logic signed [31:0]      req_target_y,
   input  logic signed [31:0]      req_target_z,
   input  logic signed [31:0]      req_source_x,
   input  logic signed [31:0]      req_source_y,
   input  logic signed [31:0]      req_source_z,
   input  logic signed [31:0]      req_strength_x,
   input  logic signed [31:0]      req_strength_y,
   input  logic signed [31:0]      req_strength_z,
   input  logic                    req_last_source,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [SAT_W-1:0] rsp_vel_x,
   output logic signed [SAT_W-1:0] rsp_vel_y,
   output logic signed [SAT_W-1:0] rsp_vel_z,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [30:0]             csr_softening
);
   state_type state_ff, state_in;

   logic [30:0]  soft_ff;
   logic signed [32:0] d_ff [3];
   logic signed [31:0] g_ff [3];
   logic         last_ff;
   logic [1:0]   idx_ff, idx_in;
   logic [1:0]   sub_ff, sub_in;
   logic [127:0] s_ff, s_in;
   logic [33:0]  root_ff, root_in;
   logic [5:0]   bit_ff, bit_in;
   logic [127:0] r2_ff, r2_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [64:0]  cp_ff [2];
   logic [64:0]  cp_in [2];
   logic         neg_ff, neg_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic signed [SAT_W-1:0] sum_ff [3];
   logic signed [SAT_W-1:0] sum_in [3];
   logic signed [SAT_W-1:0] out_ff [3];
   logic         rv_ff, rv_in;

   logic         mul_start;
   logic [63:0]  mul_a, mul_b;
   logic         mul_done;
   logic [127:0] mul_p;
   logic         div_start;
   div_ctl_type  div_ctl;
   logic [SAT_W-2:0] div_q;
   logic         accept;
   logic         out_load;
   logic signed [32:0] req_dx;
   logic [33:0]  cand;
   logic [32:0]  dabs;
   logic [63:0]  pa_mag, pb_mag;
   logic         pa_neg, pb_neg;
   logic signed [SAT_W:0] add_w;
   logic signed [SAT_W-1:0] contrib;
   logic [64:0]  ca, cb;

   bspa_serial_mul u_mul (
      .clock, .reset, .start(mul_start), .op_a(mul_a), .op_b(mul_b),
      .done(mul_done), .product(mul_p)
   );

   bspa_serial_div u_div (
      .clock, .reset, .start(div_start), .num(num_in), .den(den_ff),
      .ctl(div_ctl), .quot(div_q)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_load  = (state_ff == ST_OUT) && (!rv_ff || !rsp_stall);
   assign req_dx    = 33'(req_target_x) - 33'(req_source_x);
   assign cand      = root_ff | (34'd1 << bit_ff);

   function automatic logic [1:0] nx(input logic [1:0] i);
      return (i == 2'd2) ? 2'd0 : i + 2'd1;
   endfunction

   // cross component i = d[i+1]*g[i+2] - d[i+2]*g[i+1]
   always_comb begin
      dabs   = d_ff[idx_ff][32] ? 33'(-d_ff[idx_ff]) : 33'(d_ff[idx_ff]);
      pa_neg = d_ff[nx(idx_ff)][32] ^ g_ff[nx(nx(idx_ff))][31];
      pb_neg = d_ff[nx(nx(idx_ff))][32] ^ g_ff[nx(idx_ff)][31];
      if (sub_ff == 2'd0) begin
         pa_mag = {31'd0, d_ff[nx(idx_ff)][32] ? 33'(-d_ff[nx(idx_ff)])
                                              : 33'(d_ff[nx(idx_ff)])};
         pb_mag = {32'd0, g_ff[nx(nx(idx_ff))][31] ? 32'(-g_ff[nx(nx(idx_ff))])
                                                  : 32'(g_ff[nx(nx(idx_ff))])};
      end else begin
         pa_mag = {31'd0, d_ff[nx(nx(idx_ff))][32] ? 33'(-d_ff[nx(nx(idx_ff))])
                                                  : 33'(d_ff[nx(nx(idx_ff))])};
         pb_mag = {32'd0, g_ff[nx(idx_ff)][31] ? 32'(-g_ff[nx(idx_ff)])
                                              : 32'(g_ff[nx(idx_ff)])};
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_SQ;
         ST_SQ:    if (mul_done && idx_ff == 2'd2) state_in = ST_ROOT;
         ST_ROOT:  if (mul_done && bit_ff == 6'd0) state_in = ST_R2;
         ST_R2:    if (mul_done) state_in = ST_R3;
         ST_R3:    if (mul_done) state_in = ST_CROSS;
         ST_CROSS: if (mul_done && sub_ff == 2'd1) state_in = ST_NUM;
         ST_NUM:   if (mul_done) state_in = ST_DIV;
         ST_DIV:   if (div_ctl.done) state_in = ST_ACC;
         ST_ACC:   if (idx_ff == 2'd2) state_in = last_ff ? ST_OUT : ST_IDLE;
                   else state_in = ST_CROSS;
         ST_OUT:   if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // signed contribution and saturating add
   always_comb begin
      contrib = neg_ff ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
      add_w   = {sum_ff[idx_ff][SAT_W-1], sum_ff[idx_ff]} + {contrib[SAT_W-1], contrib};
   end

   always_comb begin
      idx_in    = idx_ff;
      sub_in    = sub_ff;
      s_in      = s_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      r2_in     = r2_ff;
      den_in    = den_ff;
      cp_in     = cp_ff;
      neg_in    = neg_ff;
      num_in    = num_ff;
      sum_in    = sum_ff;
      rv_in     = rv_ff && rsp_stall;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      ca        = cp_ff[0];
      cb        = cp_ff[1];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in    = 2'd0;
               s_in      = '0;
               mul_start = 1'b1;
               mul_a     = {31'd0, req_dx[32] ? 33'(-req_dx) : 33'(req_dx)};
               mul_b     = mul_a;
            end
         end
         ST_SQ: begin
            if (mul_done) begin
               s_in = s_ff + mul_p;
               if (idx_ff == 2'd2) begin
                  root_in   = '0;
                  bit_in    = 6'(ROOT_BITS - 1);
                  mul_start = 1'b1;
                  mul_a     = {30'd0, 34'd1 << (ROOT_BITS - 1)};
                  mul_b     = mul_a;
               end else begin
                  idx_in    = idx_ff + 2'd1;
                  mul_start = 1'b1;
               end
            end else begin
               mul_a = {31'd0, dabs};
               mul_b = {31'd0, dabs};
            end
            if (mul_done && idx_ff != 2'd2) begin
               mul_a = {31'd0, d_ff[idx_ff + 2'd1][32] ? 33'(-d_ff[idx_ff + 2'd1])
                                                       : 33'(d_ff[idx_ff + 2'd1])};
               mul_b = mul_a;
            end
         end
         ST_ROOT: begin
            mul_a = {30'd0, cand};
            mul_b = {30'd0, cand};
            if (mul_done) begin
               if (s_ff >= mul_p) root_in = cand;
               if (bit_ff == 6'd0) begin
                  mul_start = 1'b1;
                  mul_a = {29'd0, 35'((s_ff >= mul_p ? cand : root_ff)) + 35'(soft_ff)};
                  mul_b = mul_a;
                  r2_in = {93'd0, 35'((s_ff >= mul_p ? cand : root_ff)) + 35'(soft_ff)};
               end else begin
                  bit_in    = bit_ff - 6'd1;
                  mul_start = 1'b1;
                  mul_a = {30'd0, (s_ff >= mul_p ? cand : root_ff) |
                           (34'd1 << (bit_ff - 6'd1))};
                  mul_b = mul_a;
               end
            end
         end
         ST_R2: begin
            if (mul_done) begin
               // r2_ff holds r during this step
               mul_start = 1'b1;
               mul_a     = mul_p[63:0];
               mul_b     = r2_ff[63:0];
               den_in    = DEN_W'(mul_p[67:64] * 38'(r2_ff[33:0])) << 64;
               r2_in     = {mul_p[127:64], r2_ff[63:0]};
            end
         end
         ST_R3: begin
            if (mul_done) begin
               den_in    = den_ff + DEN_W'(mul_p);
               idx_in    = 2'd0;
               sub_in    = 2'd0;
               mul_start = 1'b1;
               mul_a     = {31'd0, d_ff[1][32] ? 33'(-d_ff[1]) : 33'(d_ff[1])};
               mul_b     = {32'd0, g_ff[2][31] ? 32'(-g_ff[2]) : 32'(g_ff[2])};
            end
         end
         ST_CROSS: begin
            mul_a = pa_mag;
            mul_b = pb_mag;
            if (mul_done) begin
               if (sub_ff == 2'd0) begin
                  cp_in[0]  = pa_neg ? 65'(-mul_p[64:0]) : mul_p[64:0];
                  sub_in    = 2'd1;
                  mul_start = 1'b1;
               end else begin
                  cb = pb_neg ? 65'(-mul_p[64:0]) : mul_p[64:0];
                  cp_in[1] = cb;
                  neg_in   = $signed(ca) < $signed(cb);
                  mul_start = 1'b1;
                  mul_a = neg_in ? 64'(cb - ca) : 64'(ca - cb);
                  mul_b = {32'd0, INV4PI_Q32};
               end
            end
            if (mul_done && sub_ff == 2'd0) begin
               mul_a = {31'd0, d_ff[nx(nx(idx_ff))][32] ? 33'(-d_ff[nx(nx(idx_ff))])
                                                       : 33'(d_ff[nx(nx(idx_ff))])};
               mul_b = {32'd0, g_ff[nx(idx_ff)][31] ? 32'(-g_ff[nx(idx_ff)])
                                                   : 32'(g_ff[nx(idx_ff)])};
            end
         end
         ST_NUM: begin
            if (mul_done) begin
               num_in    = mul_p << NUM_SHIFT;
               div_start = 1'b1;
            end
         end
         ST_DIV: ;
         ST_ACC: begin
            if (add_w > (SAT_W+1)'(SAT_POS)) sum_in[idx_ff] = SAT_POS;
            else if (add_w < (SAT_W+1)'(SAT_NEG)) sum_in[idx_ff] = SAT_NEG;
            else sum_in[idx_ff] = add_w[SAT_W-1:0];
            if (idx_ff != 2'd2) begin
               idx_in    = idx_ff + 2'd1;
               sub_in    = 2'd0;
               mul_start = 1'b1;
            end
            // next component operands come from the updated idx
            mul_a = {31'd0, d_ff[nx(nx(idx_ff))][32] ? 33'(-d_ff[nx(nx(idx_ff))])
                                                    : 33'(d_ff[nx(nx(idx_ff))])};
            mul_b = {32'd0, g_ff[idx_ff][31] ? 32'(-g_ff[idx_ff])
                                             : 32'(g_ff[idx_ff])};
         end
         ST_OUT: begin
            if (out_load) begin
               rv_in = 1'b1;
               sum_in[0] = '0;
               sum_in[1] = '0;
               sum_in[2] = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         soft_ff  <= 31'd1049;
         rv_ff    <= 1'b0;
         sum_ff[0] <= '0;
         sum_ff[1] <= '0;
         sum_ff[2] <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         sum_ff   <= sum_in;
         if (csr_valid && csr_ready) soft_ff <= csr_softening;
      end
      if (accept) begin
         d_ff[0] <= 33'(req_target_x) - 33'(req_source_x);
         d_ff[1] <= 33'(req_target_y) - 33'(req_source_y);
         d_ff[2] <= 33'(req_target_z) - 33'(req_source_z);
         g_ff[0] <= req_strength_x;
         g_ff[1] <= req_strength_y;
         g_ff[2] <= req_strength_z;
         last_ff <= req_last_source;
      end
      if (out_load) begin
         out_ff <= sum_ff;
      end
      idx_ff  <= idx_in;
      sub_ff  <= sub_in;
      s_ff    <= s_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      r2_ff   <= r2_in;
      den_ff  <= den_in;
      cp_ff   <= cp_in;
      neg_ff  <= neg_in;
      num_ff  <= num_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_vel_x = out_ff[0];
   assign rsp_vel_y = out_ff[1];
   assign rsp_vel_z = out_ff[2];
endmodule

// ===== rtl/bspa_serial_mul.sv =====
// Shift-add multiplier: one multiplier bit per cycle, 64x64 unsigned.
module bspa_serial_mul
   import bspa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  op_a,
   input  logic [63:0]  op_b,
   output logic         done,
   output logic [127:0] product
);
   logic [127:0] acc_ff, acc_in;
   logic [127:0] mcand_ff, mcand_in;
   logic [63:0]  mplier_ff, mplier_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = {64'd0, op_a};
         mplier_in = op_b;
         cnt_in    = 7'd0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[126:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[63:1]};
         cnt_in    = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63 || mplier_ff[63:1] == 63'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

// ===== rtl/bspa_serial_div.sv =====
// Restoring divider: one quotient bit per cycle, saturating at 2^47-1.
module bspa_serial_div
   import bspa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output div_ctl_type       ctl,
   output logic [SAT_W-2:0]  quot
);
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [7:0]       cnt_ff, cnt_in;
   logic             sat_ff, sat_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NUM_W:0]   trial;
   logic [NUM_W-1:0] qn;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      sat_in  = sat_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[NUM_W-1:0], num_ff[NUM_W-1]};
      qn      = {q_ff[NUM_W-2:0], 1'b0};
      if (start) begin
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
         q_in    = '0;
         cnt_in  = 8'd0;
         sat_in  = 1'b0;
         busy_in = (den != '0);
         done_in = (den == '0);
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (trial >= {{(NUM_W+1-DEN_W){1'b0}}, den_ff}) begin
            rem_in = trial - {{(NUM_W+1-DEN_W){1'b0}}, den_ff};
            qn[0]  = 1'b1;
         end else begin
            rem_in = trial;
         end
         q_in   = qn;
         cnt_in = cnt_ff + 8'd1;
         if (qn > {{(NUM_W-SAT_W+1){1'b0}}, {(SAT_W-1){1'b1}}}) begin
            sat_in  = 1'b1;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (cnt_ff == 8'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      sat_ff <= sat_in;
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   assign quot = sat_ff ? {(SAT_W-1){1'b1}} : q_ff[SAT_W-2:0];
endmodule
